// ===== rtl/core/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Entry and control types, operation and status codes, default depth.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default number of entries
  localparam int DEPTH_DEF = 16;
  // width of value and priority fields
  localparam int DW        = 32;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // one stored entry
  typedef struct packed {
    logic                 vld;
    logic signed [DW-1:0] val;
    logic signed [DW-1:0] pri;
  } entry_t;

  // per-cycle shift command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on insert it keeps, loads the new entry or takes its left
// neighbor; on removal it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spq_pkg::ctl_t                 ctl,
  input  logic signed [spq_pkg::DW-1:0] new_val,
  input  logic signed [spq_pkg::DW-1:0] new_pri,
  input  spq_pkg::entry_t               left_ent,
  input  logic                          left_keep,
  input  spq_pkg::entry_t               right_ent,
  output spq_pkg::entry_t               ent,
  output logic                          keep
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // stay in place when the stored entry is served no later than the new one
  assign keep = ent_r.vld && (ent_r.pri <= new_pri);

  // next entry selection
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq) begin
      if (keep) begin
        ent_nxt = ent_r;
      end else if (left_keep) begin
        ent_nxt.vld = 1'b1;
        ent_nxt.val = new_val;
        ent_nxt.pri = new_pri;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctl.deq) begin
      ent_nxt = right_ent;
    end
  end

  // valid bit is reset, payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.val <= ent_nxt.val;
    ent_r.pri <= ent_nxt.pri;
  end

  assign ent = ent_r;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue held as a sorted shift chain
// Enqueue places an entry behind all entries of equal or smaller priority
// number; dequeue returns the front entry. One result per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_operation (enqueue or dequeue),
//   in_item_value and in_item_priority. Every accepted item yields exactly one
//   result on out_valid/out_ready: the dequeued entry (or zeros), a status
//   code (done, dequeue on empty, enqueue dropped when full), the entry count
//   after the item and an empty flag.
//   An accepted item's result appears in the output register in the next cycle.
//   Throughput is one item per cycle while the receiver keeps up: all DEPTH
//   cells compare against the new priority and shift in parallel, so the rate
//   is set by one 32-bit signed compare plus a four-way select per cell.
//   The output register accepts a new item in the same cycle its result is
//   taken; while the receiver stalls, in_ready stays low and the queue holds.
//   Reset clears the entry count, all cell valid bits and the output valid;
//   the queue is empty and ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic signed [spq_pkg::DW-1:0] in_item_value,
  input  logic signed [spq_pkg::DW-1:0] in_item_priority,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_out_valid,
  output logic signed [spq_pkg::DW-1:0] out_out_value,
  output logic signed [spq_pkg::DW-1:0] out_out_priority,
  output logic [1:0]                    out_status,
  output logic [4:0]                    out_entry_count,
  output logic                          out_queue_empty
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  entry_t             cells [DEPTH];
  logic [DEPTH-1:0]   keeps;
  ctl_t               ctl;
  logic               acc;
  logic               full;
  logic               empty;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;
  logic [CW+4:0]      cnt_ext;

  logic               out_valid_r;
  logic               res_valid_r;
  logic [DW-1:0]      res_value_r;
  logic [DW-1:0]      res_prio_r;
  logic [1:0]         res_status_r;
  logic [4:0]         res_count_r;
  logic               res_empty_r;

  // handshake and shift commands
  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign ctl.enq  = acc && (in_operation == OP_ENQ) && !full;
  assign ctl.deq  = acc && (in_operation == OP_DEQ) && !empty;

  // cell chain, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_keep;

    if (i == 0) begin : g_first
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = cells[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = cells[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_val   (in_item_value),
      .new_pri   (in_item_priority),
      .left_ent  (left_ent),
      .left_keep (left_keep),
      .right_ent (right_ent),
      .ent       (cells[i]),
      .keep      (keeps[i])
    );
  end

  // entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.enq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign cnt_ext = {5'b0, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= acc;
    end
    if (acc) begin
      res_valid_r  <= ctl.deq;
      res_value_r  <= ctl.deq ? cells[0].val : '0;
      res_prio_r   <= ctl.deq ? cells[0].pri : '0;
      res_count_r  <= cnt_ext[4:0];
      res_empty_r  <= (cnt_nxt == '0);
      if (in_operation == OP_ENQ) begin
        res_status_r <= full ? ST_FULL : ST_DONE;
      end else begin
        res_status_r <= empty ? ST_EMPTY : ST_DONE;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_out_valid    = res_valid_r;
  assign out_out_value    = res_value_r;
  assign out_out_priority = res_prio_r;
  assign out_status       = res_status_r;
  assign out_entry_count  = res_count_r;
  assign out_queue_empty  = res_empty_r;

  // front cell is occupied exactly when the count is nonzero
  a_front_vld : assert property (@(posedge clk) disable iff (!rst_n)
    cells[0].vld == (cnt_r != '0))
    else $error("front cell valid disagrees with count");

  // last cell is occupied exactly when the queue is full
  a_back_vld : assert property (@(posedge clk) disable iff (!rst_n)
    cells[DEPTH-1].vld == full)
    else $error("last cell valid disagrees with full");

  // first two cells stay in priority order
  a_sorted : assert property (@(posedge clk) disable iff (!rst_n)
    (cells[0].vld && cells[1].vld) |-> (cells[0].pri <= cells[1].pri))
    else $error("front cells out of order");

  // a dequeue returns the front entry
  a_deq_front : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.deq |=> (out_valid && out_out_valid &&
                 out_out_value == $past(cells[0].val) &&
                 out_out_priority == $past(cells[0].pri)))
    else $error("dequeue did not return front entry");

  // an enqueue into a full queue is dropped
  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_operation == OP_ENQ) && full) |=>
      (out_status == ST_FULL && $stable(cnt_r)))
    else $error("enqueue into full queue not dropped");

endmodule
